@@ src/bfb_pkg.sv @@
package bfb_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 32;
  localparam int MAX_CHANNELS = 3;
  localparam int STORE_BYTES  = (MAX_WIDTH / 8) * MAX_HEIGHT * MAX_CHANNELS;
  localparam int ADDR_W       = $clog2(STORE_BYTES);

  // Field and register widths
  localparam int SW_W     = 7;
  localparam int SH_W     = 6;
  localparam int CC_W     = 2;
  localparam int WB_W     = SW_W - 3;
  localparam int CFG_W    = 7;
  localparam int CFG_IX_W = 2;
  localparam int OP_W     = 3;
  localparam int RA_W     = 10;
  localparam int PROD_W   = 8 + WB_W;
  localparam int SUM_W    = ((PROD_W > ADDR_W) ? PROD_W : ADDR_W) + 1;
  localparam int PLANE_W  = WB_W + SH_W;
  localparam int PCOL_W   = 1 << CC_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR        = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_PIXEL    = 3'd1;
  localparam logic [OP_W-1:0] OP_START_BITMAP = 3'd2;
  localparam logic [OP_W-1:0] OP_HEX_CHAR     = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_BYTE    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  // ASCII bounds for hex digits
  localparam logic [7:0] ASCII_0 = 8'h30;
  localparam logic [7:0] ASCII_9 = 8'h39;
  localparam logic [7:0] ASCII_A = 8'h61;
  localparam logic [7:0] ASCII_F = 8'h66;

  localparam logic [7:0] MSB_MASK = 8'b1000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RD_ISSUE,
    S_RD_DATA,
    S_BLIT,
    S_PIX_CHK,
    S_PIX_RD,
    S_PIX_WR,
    S_DONE
  } state_t;

  // Screen geometry in use
  typedef struct packed {
    logic [WB_W-1:0] wbytes;
    logic [SH_W-1:0] height;
    logic [CC_W-1:0] chans;
  } geom_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [7:0]      pos_x;
    logic [7:0]      pos_y;
    logic [7:0]      pixel_color;
    logic [7:0]      bitmap_width;
    logic [7:0]      bitmap_height;
    logic [7:0]      hex_char;
    logic [RA_W-1:0] read_address;
  } item_t;

  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
    logic [7:0]      data;
  } res_t;

  // {hit, nibble}; hit is low for anything but 0-9 and a-f
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= ASCII_0 && c <= ASCII_9) begin
      r = {1'b1, 4'(c - ASCII_0)};
    end else if (c >= ASCII_A && c <= ASCII_F) begin
      r = {1'b1, 4'(c - ASCII_A + 8'd10)};
    end
    return r;
  endfunction

endpackage

@@ src/bfb_store.sv @@
module bfb_store
  import bfb_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/bfb_engine.sv @@
module bfb_engine
  import bfb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  geom_t geom,
  input  logic  start,
  input  item_t item,
  output logic  ready,
  output res_t  res,
  input  logic  res_ready
);

  state_t state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [7:0]        x_r, x_nxt, y_r, y_nxt, color_r, color_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [3:0]        nib_r, nib_nxt;
  logic [CC_W-1:0]   c_r, c_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic [PCOL_W-1:0] pcol_r, pcol_nxt;
  logic [7:0]        data_r, data_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clr_item_r, clr_item_nxt;

  // bitmap stream state
  logic [7:0] ox_r, ox_nxt, oy_r, oy_nxt, bw_r, bw_nxt, bh_r, bh_nxt;
  logic [7:0] bc_r, bc_nxt, bcol_r, bcol_nxt, brow_r, brow_nxt;
  logic [3:0] lnib_r, lnib_nxt;

  // memory port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  // shared address adder and helpers
  logic [SUM_W-1:0]   add_a, add_b, sum;
  logic [PROD_W-1:0]  row_base;
  logic [PLANE_W-1:0] plane_sz;
  logic [4:0]         dec;
  logic [8:0]         bcol_inc;
  logic               color_hi;
  logic [PCOL_W-1:0]  pcol_calc;
  logic               clip;

  bfb_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign row_base = PROD_W'(y_r) * PROD_W'(geom.wbytes);
  assign plane_sz = PLANE_W'(geom.wbytes) * PLANE_W'(geom.height);
  assign sum      = add_a + add_b;
  assign dec      = hex_decode(item.hex_char);
  assign bcol_inc = {1'b0, bcol_r} + 9'd1;
  assign clip     = ({3'b000, x_r[7:3]} >= {4'b0000, geom.wbytes}) ||
                    (y_r >= {2'b00, geom.height}) || (geom.chans == '0);

  // top channel forced on when colour bits exceed the channel count
  always_comb begin
    color_hi = (color_r >> geom.chans) != 8'd0;
    for (int i = 0; i < PCOL_W; i++) begin
      pcol_calc[i] = color_r[i] | (color_hi && (CC_W'(i) == geom.chans - 1'b1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      clr_item_r <= 1'b0;
      k_r        <= '0;
      ox_r       <= '0;
      oy_r       <= '0;
      bw_r       <= '0;
      bh_r       <= '0;
      bc_r       <= '0;
      bcol_r     <= '0;
      brow_r     <= '0;
      lnib_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      clr_item_r <= clr_item_nxt;
      k_r        <= k_nxt;
      ox_r       <= ox_nxt;
      oy_r       <= oy_nxt;
      bw_r       <= bw_nxt;
      bh_r       <= bh_nxt;
      bc_r       <= bc_nxt;
      bcol_r     <= bcol_nxt;
      brow_r     <= brow_nxt;
      lnib_r     <= lnib_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    color_r <= color_nxt;
    nib_r   <= nib_nxt;
    c_r     <= c_nxt;
    addr_r  <= addr_nxt;
    mask_r  <= mask_nxt;
    pcol_r  <= pcol_nxt;
    data_r  <= data_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    color_nxt    = color_r;
    k_nxt        = k_r;
    nib_nxt      = nib_r;
    c_nxt        = c_r;
    addr_nxt     = addr_r;
    mask_nxt     = mask_r;
    pcol_nxt     = pcol_r;
    data_nxt     = data_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_item_nxt = clr_item_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    bw_nxt       = bw_r;
    bh_nxt       = bh_r;
    bc_nxt       = bc_r;
    bcol_nxt     = bcol_r;
    brow_nxt     = brow_r;
    lnib_nxt     = lnib_r;
    mem_we       = 1'b0;
    mem_waddr    = addr_r;
    mem_wdata    = '0;
    mem_raddr    = addr_r;
    add_a        = SUM_W'(row_base);
    add_b        = SUM_W'(x_r[7:3]);
    res.valid    = 1'b0;
    res.op       = op_r;
    res.data     = data_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = item.op;
          data_nxt = '0;
          case (item.op)
            OP_CLEAR: begin
              clr_cnt_nxt  = '0;
              clr_item_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            OP_SET_PIXEL: begin
              x_nxt     = item.pos_x;
              y_nxt     = item.pos_y;
              color_nxt = item.pixel_color;
              state_nxt = S_PIX_CHK;
            end
            OP_START_BITMAP: begin
              ox_nxt    = item.pos_x;
              oy_nxt    = item.pos_y;
              bw_nxt    = item.bitmap_width;
              bh_nxt    = item.bitmap_height;
              bc_nxt    = item.pixel_color;
              bcol_nxt  = '0;
              brow_nxt  = '0;
              lnib_nxt  = '0;
              state_nxt = S_DONE;
            end
            OP_HEX_CHAR: begin
              // a non-hex character repeats the previous nibble
              if (dec[4]) begin
                lnib_nxt = dec[3:0];
                nib_nxt  = dec[3:0];
              end else begin
                nib_nxt = lnib_r;
              end
              k_nxt     = '0;
              state_nxt = S_BLIT;
            end
            OP_READ_BYTE: begin
              if (int'(item.read_address) < STORE_BYTES) begin
                addr_nxt  = ADDR_W'(item.read_address);
                state_nxt = S_RD_ISSUE;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // zero sweep, one byte a cycle
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == ADDR_W'(STORE_BYTES - 1)) begin
          state_nxt = clr_item_r ? S_DONE : S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      S_RD_ISSUE: begin
        mem_raddr = addr_r;
        state_nxt = S_RD_DATA;
      end

      S_RD_DATA: begin
        data_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end

      // one bitmap pixel per visit: place it if its nibble bit is set, then advance the cursor
      S_BLIT: begin
        if (k_r == 3'd4 || bw_r == '0 || brow_r >= bh_r) begin
          state_nxt = S_DONE;
        end else begin
          x_nxt     = ox_r + bcol_r;
          y_nxt     = oy_r + brow_r;
          color_nxt = bc_r;
          k_nxt     = k_r + 1'b1;
          if (bcol_inc >= {1'b0, bw_r}) begin
            bcol_nxt = '0;
            brow_nxt = brow_r + 1'b1;
          end else begin
            bcol_nxt = bcol_inc[7:0];
          end
          if (nib_r[2'd3 - k_r[1:0]]) begin
            state_nxt = S_PIX_CHK;
          end
        end
      end

      // clip, byte address of plane 0, bit mask, channel colours
      S_PIX_CHK: begin
        if (clip) begin
          state_nxt = (op_r == OP_HEX_CHAR) ? S_BLIT : S_DONE;
        end else begin
          add_a     = SUM_W'(row_base);
          add_b     = SUM_W'(x_r[7:3]);
          addr_nxt  = sum[ADDR_W-1:0];
          mask_nxt  = MSB_MASK >> x_r[2:0];
          pcol_nxt  = pcol_calc;
          c_nxt     = '0;
          state_nxt = S_PIX_RD;
        end
      end

      S_PIX_RD: begin
        if (c_r == geom.chans) begin
          state_nxt = (op_r == OP_HEX_CHAR) ? S_BLIT : S_DONE;
        end else begin
          mem_raddr = addr_r;
          state_nxt = S_PIX_WR;
        end
      end

      // modify and write back, step to the next plane
      S_PIX_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = pcol_r[c_r] ? (mem_rdata | mask_r) : (mem_rdata & ~mask_r);
        add_a     = SUM_W'(addr_r);
        add_b     = SUM_W'(plane_sz);
        addr_nxt  = sum[ADDR_W-1:0];
        c_nxt     = c_r + 1'b1;
        state_nxt = S_PIX_RD;
      end

      S_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ready = (state_r == S_IDLE);

endmodule

@@ src/bitplane_framebuffer_blitter_unit.sv @@
// Channel   Ports                               Direction
// in        in_valid / in_stall, in_* fields    item in, one per operation
// out       out_valid / out_stall, out_read_data  one result per item
// cfg       cfg_wr_en, cfg_index, cfg_wdata     register writes, no wait
//
// The engine takes one item at a time and only when idle; all memory
// traffic goes through the one write port and the one registered read
// port of the frame store.
// After reset the whole store is swept to zero; in_stall is high then.
// The result register frees the engine: a new item is taken while a result
// waits, and the engine holds its next result until out_stall drops.
module bitplane_framebuffer_blitter_unit
  import bfb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_op,
  input  logic [7:0]          in_pos_x,
  input  logic [7:0]          in_pos_y,
  input  logic [7:0]          in_pixel_color,
  input  logic [7:0]          in_bitmap_width,
  input  logic [7:0]          in_bitmap_height,
  input  logic [7:0]          in_hex_char,
  input  logic [RA_W-1:0]     in_read_address,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_read_data,
  input  logic                cfg_wr_en,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  logic [SW_W-1:0] sw_r, sw_cl;
  logic [SH_W-1:0] sh_r, sh_cl;
  logic [CC_W-1:0] cc_r, cc_cl;
  geom_t           geom;
  item_t           item;
  res_t            res;
  logic            eng_ready, res_ready, start;
  logic            out_valid_r;
  logic [7:0]      out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= SW_W'(32);
      sh_r <= SH_W'(16);
      cc_r <= CC_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  sw_r <= cfg_wdata[SW_W-1:0];
        CFG_SCREEN_HEIGHT: sh_r <= cfg_wdata[SH_W-1:0];
        CFG_CHANNEL_COUNT: cc_r <= cfg_wdata[CC_W-1:0];
        default: ;
      endcase
    end
  end

  // limit to the store geometry; width rounds down to whole bytes
  assign sw_cl       = (int'(sw_r) < MAX_WIDTH) ? sw_r : SW_W'(MAX_WIDTH);
  assign sh_cl       = (int'(sh_r) < MAX_HEIGHT) ? sh_r : SH_W'(MAX_HEIGHT);
  assign cc_cl       = (int'(cc_r) < MAX_CHANNELS) ? cc_r : CC_W'(MAX_CHANNELS);
  assign geom.wbytes = sw_cl[SW_W-1:3];
  assign geom.height = sh_cl;
  assign geom.chans  = cc_cl;

  assign item.op            = in_op;
  assign item.pos_x         = in_pos_x;
  assign item.pos_y         = in_pos_y;
  assign item.pixel_color   = in_pixel_color;
  assign item.bitmap_width  = in_bitmap_width;
  assign item.bitmap_height = in_bitmap_height;
  assign item.hex_char      = in_hex_char;
  assign item.read_address  = in_read_address;

  assign in_stall = !eng_ready;
  assign start    = in_valid && eng_ready;

  bfb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .start     (start),
    .item      (item),
    .ready     (eng_ready),
    .res       (res),
    .res_ready (res_ready)
  );

  // result register
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

`ifndef NO_ASSERTIONS
  // the zero sweep after reset holds off input
  a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("item taken during reset sweep");

  // only a byte read returns a nonzero result
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.op != OP_READ_BYTE) |-> (res.data == 8'd0))
    else $error("nonzero result for non-read op");

  // every accepted item leaves the engine busy in the cycle after it is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("engine ready right after taking an item");
`endif

endmodule
